>>> hdl/stl_pkg.sv
// Package for the source text lexer: lexer modes, token kinds, error codes,
// character codes, the result item type and the result queue sizes.
// No dependencies.
package stl_pkg;

  // Lexer modes between input items.
  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_COMMENT = 4'd1,
    MODE_AT      = 4'd2,
    MODE_COLON   = 4'd3,
    MODE_INT     = 4'd4,
    MODE_IDENT   = 4'd5,
    MODE_STRING  = 4'd6,
    MODE_ESCAPE  = 4'd7,
    MODE_ERROR   = 4'd8
  } lex_mode_e;

  // Token kinds; kinds 0 to 8 are the single-character punctuators.
  localparam logic [4:0] KIND_SEMI        = 5'd0;
  localparam logic [4:0] KIND_EQUALS      = 5'd1;
  localparam logic [4:0] KIND_CARET       = 5'd2;
  localparam logic [4:0] KIND_LBRACE      = 5'd3;
  localparam logic [4:0] KIND_RBRACE      = 5'd4;
  localparam logic [4:0] KIND_LPAREN      = 5'd5;
  localparam logic [4:0] KIND_RPAREN      = 5'd6;
  localparam logic [4:0] KIND_LBRACKET    = 5'd7;
  localparam logic [4:0] KIND_RBRACKET    = 5'd8;
  localparam logic [4:0] KIND_AT          = 5'd9;
  localparam logic [4:0] KIND_ATAT        = 5'd10;
  localparam logic [4:0] KIND_COLON       = 5'd11;
  localparam logic [4:0] KIND_COLONCOLON  = 5'd12;
  localparam logic [4:0] KIND_INT         = 5'd13;
  localparam logic [4:0] KIND_IDENT       = 5'd14;
  localparam logic [4:0] KIND_STRING      = 5'd15;
  localparam logic [4:0] KIND_END         = 5'd16;

  // Error codes.
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_INT_RANGE  = 3'd1;
  localparam logic [2:0] ERR_NO_DIGITS  = 3'd2;
  localparam logic [2:0] ERR_LONG_IDENT = 3'd3;
  localparam logic [2:0] ERR_UNTERM     = 3'd4;
  localparam logic [2:0] ERR_LONG_STR   = 3'd5;
  localparam logic [2:0] ERR_BAD_ESCAPE = 3'd6;
  localparam logic [2:0] ERR_BAD_CHAR   = 3'd7;

  // Character codes.
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_EQUALS    = 8'h3D;
  localparam logic [7:0] CH_AT        = 8'h40;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_CARET     = 8'h5E;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_LOWER_N   = 8'h6E;
  localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  // Body length limits, in characters.
  localparam logic [7:0] MAX_IDENT_LEN  = 8'd40;
  localparam logic [7:0] MAX_STRING_LEN = 8'd200;

  // Result queue: two results per item at most, so four entries let an
  // item be taken while up to two finished results still wait.
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = 2;
  localparam int unsigned RES_CNT_W = 3;

  // One result item.
  typedef struct packed {
    logic [4:0]  kind;
    logic        done;
    logic [31:0] int_value;
    logic        char_valid;
    logic [7:0]  text_char;
    logic [2:0]  err;
    logic        last;
  } result_t;

endpackage

>>> hdl/source_text_lexer.sv
// Source text lexer top level: one byte or end-of-text item in, token
// results out through a four-entry result queue.
// Depends on stl_pkg.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+---------------------------------
//  input   | in        | in_valid_i / in_stall_o   | action_i, text_byte_i
//  output  | out       | out_valid_o / out_stall_i | token_kind_o .. error_code_o, last_o
//
// One item is taken per cycle while the input is not stalled; its results are computed
// in the same cycle and written to the result queue, which hands out one result per cycle
// while out_stall_i is low. Items with two results therefore take two queue entries; the
// queue lets the input run ahead while results wait.
// The input stalls while three or more results are queued.
// Reset is asynchronous and active low; it clears the mode, the lexer
// state and the queue pointers.
module source_text_lexer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               action_i,
  input  logic [7:0]         text_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         token_kind_o,
  output logic               token_done_o,
  output logic signed [31:0] int_value_o,
  output logic               text_char_valid_o,
  output logic [7:0]         text_char_o,
  output logic [2:0]         error_code_o,
  output logic               last_o
);

  localparam int unsigned RES_CNT_W = stl_pkg::RES_CNT_W;
  localparam int unsigned RES_PTR_W = stl_pkg::RES_PTR_W;

  // Lexer state.
  stl_pkg::lex_mode_e mode_q, mode_d;
  logic [30:0] acc_q, acc_d;
  logic        minus_q, minus_d;
  logic        digit_q, digit_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [2:0]  err_q, err_d;

  // Result queue.
  stl_pkg::result_t                  res_mem [stl_pkg::RES_DEPTH];
  logic [stl_pkg::RES_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [stl_pkg::RES_CNT_W-1:0]     count_q, count_d;

  // Handshakes.
  logic in_acc;
  logic out_acc;

  // Byte classification.
  logic       is_dig, is_let, is_ws, is_punct, is_body;
  logic [4:0] punct_kind;

  // Digit accumulation.
  logic [30:0] acc_base;
  logic [3:0]  digit_val;
  logic [34:0] prod;
  logic        ovf;
  logic [31:0] int_mag;
  logic [31:0] int_signed;

  // Results of this item.
  logic              relex;
  logic              pre_v, main_v;
  stl_pkg::result_t  pre_r, main_r;
  stl_pkg::result_t  res0, res1;
  logic [1:0]        n_push;

  function automatic stl_pkg::result_t mk_res(logic [4:0] kind, logic done,
                                              logic [31:0] ival, logic cvalid,
                                              logic [7:0] ch, logic [2:0] err);
    stl_pkg::result_t r;
    r.kind       = kind;
    r.done       = done;
    r.int_value  = ival;
    r.char_valid = cvalid;
    r.text_char  = ch;
    r.err        = err;
    r.last       = 1'b0;
    return r;
  endfunction

  assign in_stall_o  = (count_q >= RES_CNT_W'(3));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign out_acc     = out_valid_o && !out_stall_i;

  // Classify the incoming byte.
  always_comb begin
    is_dig   = (text_byte_i >= stl_pkg::CH_ZERO) && (text_byte_i <= stl_pkg::CH_NINE);
    is_let   = ((text_byte_i >= stl_pkg::CH_LOWER_A) && (text_byte_i <= stl_pkg::CH_LOWER_Z))
            || ((text_byte_i >= stl_pkg::CH_UPPER_A) && (text_byte_i <= stl_pkg::CH_UPPER_Z));
    is_ws    = (text_byte_i == stl_pkg::CH_SPACE) || (text_byte_i == stl_pkg::CH_NEWLINE);
    is_body  = is_dig || is_let;
    is_punct = 1'b1;
    case (text_byte_i)
      stl_pkg::CH_SEMI:     punct_kind = stl_pkg::KIND_SEMI;
      stl_pkg::CH_EQUALS:   punct_kind = stl_pkg::KIND_EQUALS;
      stl_pkg::CH_CARET:    punct_kind = stl_pkg::KIND_CARET;
      stl_pkg::CH_LBRACE:   punct_kind = stl_pkg::KIND_LBRACE;
      stl_pkg::CH_RBRACE:   punct_kind = stl_pkg::KIND_RBRACE;
      stl_pkg::CH_LPAREN:   punct_kind = stl_pkg::KIND_LPAREN;
      stl_pkg::CH_RPAREN:   punct_kind = stl_pkg::KIND_RPAREN;
      stl_pkg::CH_LBRACKET: punct_kind = stl_pkg::KIND_LBRACKET;
      stl_pkg::CH_RBRACKET: punct_kind = stl_pkg::KIND_RBRACKET;
      default: begin
        punct_kind = stl_pkg::KIND_SEMI;
        is_punct   = 1'b0;
      end
    endcase
  end

  // Decimal accumulation: acc * 10 + digit, built from two shifts.
  assign acc_base   = (mode_q == stl_pkg::MODE_INT) ? acc_q : '0;
  assign digit_val  = 4'(text_byte_i - stl_pkg::CH_ZERO);
  assign prod       = 35'({acc_base, 3'b000}) + 35'({acc_base, 1'b0}) + 35'(digit_val);
  assign ovf        = |prod[34:31];
  assign int_mag    = {1'b0, acc_q};
  assign int_signed = minus_q ? (32'd0 - int_mag) : int_mag;

  // A byte that ends a pending token, or arrives between tokens, is
  // lexed again from the idle mode in the same cycle.
  always_comb begin
    relex = 1'b0;
    if (!action_i) begin
      unique case (mode_q)
        stl_pkg::MODE_COMMENT, stl_pkg::MODE_STRING,
        stl_pkg::MODE_ESCAPE, stl_pkg::MODE_ERROR: relex = 1'b0;
        stl_pkg::MODE_AT:    relex = (text_byte_i != stl_pkg::CH_AT);
        stl_pkg::MODE_COLON: relex = (text_byte_i != stl_pkg::CH_COLON);
        stl_pkg::MODE_INT:   relex = !is_dig && digit_q;
        stl_pkg::MODE_IDENT: relex = !is_body;
        default:             relex = 1'b1;
      endcase
    end
  end

  // Next lexer state.
  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    minus_d = minus_q;
    digit_d = digit_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    if (action_i) begin
      // End of text returns the lexer to its reset state.
      mode_d  = stl_pkg::MODE_IDLE;
      acc_d   = '0;
      minus_d = 1'b0;
      digit_d = 1'b0;
      cnt_d   = '0;
      err_d   = stl_pkg::ERR_NONE;
    end else begin
      unique case (mode_q)
        stl_pkg::MODE_COMMENT: begin
          if (text_byte_i == stl_pkg::CH_NEWLINE) mode_d = stl_pkg::MODE_IDLE;
        end
        stl_pkg::MODE_AT, stl_pkg::MODE_COLON: begin
          mode_d = stl_pkg::MODE_IDLE;
        end
        stl_pkg::MODE_INT: begin
          if (is_dig) begin
            digit_d = 1'b1;
            if (ovf) begin
              mode_d = stl_pkg::MODE_ERROR;
              err_d  = stl_pkg::ERR_INT_RANGE;
            end else begin
              acc_d = prod[30:0];
            end
          end else if (!digit_q) begin
            mode_d = stl_pkg::MODE_ERROR;
            err_d  = stl_pkg::ERR_NO_DIGITS;
          end else begin
            mode_d = stl_pkg::MODE_IDLE;
          end
        end
        stl_pkg::MODE_IDENT: begin
          if (is_body) begin
            if (cnt_q >= stl_pkg::MAX_IDENT_LEN) begin
              mode_d = stl_pkg::MODE_ERROR;
              err_d  = stl_pkg::ERR_LONG_IDENT;
            end else begin
              cnt_d = cnt_q + 8'd1;
            end
          end else begin
            mode_d = stl_pkg::MODE_IDLE;
          end
        end
        stl_pkg::MODE_STRING: begin
          if (text_byte_i == stl_pkg::CH_QUOTE) begin
            mode_d = stl_pkg::MODE_IDLE;
          end else if (cnt_q >= stl_pkg::MAX_STRING_LEN) begin
            mode_d = stl_pkg::MODE_ERROR;
            err_d  = stl_pkg::ERR_LONG_STR;
          end else if (text_byte_i == stl_pkg::CH_BACKSLASH) begin
            mode_d = stl_pkg::MODE_ESCAPE;
          end else begin
            cnt_d = cnt_q + 8'd1;
          end
        end
        stl_pkg::MODE_ESCAPE: begin
          if ((text_byte_i == stl_pkg::CH_QUOTE) || (text_byte_i == stl_pkg::CH_BACKSLASH)
              || (text_byte_i == stl_pkg::CH_LOWER_N)) begin
            mode_d = stl_pkg::MODE_STRING;
            cnt_d  = cnt_q + 8'd1;
          end else begin
            mode_d = stl_pkg::MODE_ERROR;
            err_d  = stl_pkg::ERR_BAD_ESCAPE;
          end
        end
        default: begin
        end
      endcase

      // Start of a new token from the idle mode.
      if (relex && !is_ws && !is_punct) begin
        if (text_byte_i == stl_pkg::CH_HASH) begin
          mode_d = stl_pkg::MODE_COMMENT;
        end else if (text_byte_i == stl_pkg::CH_QUOTE) begin
          mode_d = stl_pkg::MODE_STRING;
          cnt_d  = '0;
        end else if (text_byte_i == stl_pkg::CH_AT) begin
          mode_d = stl_pkg::MODE_AT;
        end else if (text_byte_i == stl_pkg::CH_COLON) begin
          mode_d = stl_pkg::MODE_COLON;
        end else if (is_dig || (text_byte_i == stl_pkg::CH_MINUS)) begin
          mode_d  = stl_pkg::MODE_INT;
          minus_d = (text_byte_i == stl_pkg::CH_MINUS);
          digit_d = is_dig;
          acc_d   = is_dig ? prod[30:0] : '0;
        end else if (is_let) begin
          mode_d = stl_pkg::MODE_IDENT;
          cnt_d  = 8'd1;
        end else begin
          mode_d = stl_pkg::MODE_ERROR;
          err_d  = stl_pkg::ERR_BAD_CHAR;
        end
      end
    end
  end

  // Results of this item: an optional completion of the pending token,
  // then at most one result from the byte itself.
  always_comb begin
    pre_v  = 1'b0;
    pre_r  = '0;
    main_v = 1'b0;
    main_r = '0;
    if (action_i) begin
      main_v = 1'b1;
      main_r = mk_res(stl_pkg::KIND_END, 1'b1, '0, 1'b0, '0, err_q);
      unique case (mode_q)
        stl_pkg::MODE_AT: begin
          pre_v = 1'b1;
          pre_r = mk_res(stl_pkg::KIND_AT, 1'b1, '0, 1'b0, '0, stl_pkg::ERR_NONE);
        end
        stl_pkg::MODE_COLON: begin
          pre_v = 1'b1;
          pre_r = mk_res(stl_pkg::KIND_COLON, 1'b1, '0, 1'b0, '0, stl_pkg::ERR_NONE);
        end
        stl_pkg::MODE_INT: begin
          if (digit_q) begin
            pre_v = 1'b1;
            pre_r = mk_res(stl_pkg::KIND_INT, 1'b1, int_signed, 1'b0, '0,
                           stl_pkg::ERR_NONE);
          end else begin
            main_r.err = stl_pkg::ERR_NO_DIGITS;
          end
        end
        stl_pkg::MODE_IDENT: begin
          pre_v = 1'b1;
          pre_r = mk_res(stl_pkg::KIND_IDENT, 1'b1, '0, 1'b0, '0, stl_pkg::ERR_NONE);
        end
        stl_pkg::MODE_STRING: main_r.err = stl_pkg::ERR_UNTERM;
        stl_pkg::MODE_ESCAPE: main_r.err = stl_pkg::ERR_BAD_ESCAPE;
        default: begin
        end
      endcase
    end else begin
      unique case (mode_q)
        stl_pkg::MODE_AT: begin
          pre_v = 1'b1;
          pre_r = mk_res(relex ? stl_pkg::KIND_AT : stl_pkg::KIND_ATAT, 1'b1, '0, 1'b0,
                         '0, stl_pkg::ERR_NONE);
        end
        stl_pkg::MODE_COLON: begin
          pre_v = 1'b1;
          pre_r = mk_res(relex ? stl_pkg::KIND_COLON : stl_pkg::KIND_COLONCOLON, 1'b1,
                         '0, 1'b0, '0, stl_pkg::ERR_NONE);
        end
        stl_pkg::MODE_INT: begin
          if (is_dig) begin
            if (ovf) begin
              main_v = 1'b1;
              main_r = mk_res(stl_pkg::KIND_SEMI, 1'b0, '0, 1'b0, '0,
                              stl_pkg::ERR_INT_RANGE);
            end
          end else if (!digit_q) begin
            main_v = 1'b1;
            main_r = mk_res(stl_pkg::KIND_SEMI, 1'b0, '0, 1'b0, '0, stl_pkg::ERR_NO_DIGITS);
          end else begin
            pre_v = 1'b1;
            pre_r = mk_res(stl_pkg::KIND_INT, 1'b1, int_signed, 1'b0, '0,
                           stl_pkg::ERR_NONE);
          end
        end
        stl_pkg::MODE_IDENT: begin
          if (is_body) begin
            main_v = 1'b1;
            if (cnt_q >= stl_pkg::MAX_IDENT_LEN) begin
              main_r = mk_res(stl_pkg::KIND_SEMI, 1'b0, '0, 1'b0, '0,
                              stl_pkg::ERR_LONG_IDENT);
            end else begin
              main_r = mk_res(stl_pkg::KIND_IDENT, 1'b0, '0, 1'b1, text_byte_i,
                              stl_pkg::ERR_NONE);
            end
          end else begin
            pre_v = 1'b1;
            pre_r = mk_res(stl_pkg::KIND_IDENT, 1'b1, '0, 1'b0, '0, stl_pkg::ERR_NONE);
          end
        end
        stl_pkg::MODE_STRING: begin
          if (text_byte_i == stl_pkg::CH_QUOTE) begin
            main_v = 1'b1;
            main_r = mk_res(stl_pkg::KIND_STRING, 1'b1, '0, 1'b0, '0, stl_pkg::ERR_NONE);
          end else if (cnt_q >= stl_pkg::MAX_STRING_LEN) begin
            main_v = 1'b1;
            main_r = mk_res(stl_pkg::KIND_SEMI, 1'b0, '0, 1'b0, '0, stl_pkg::ERR_LONG_STR);
          end else if (text_byte_i != stl_pkg::CH_BACKSLASH) begin
            main_v = 1'b1;
            main_r = mk_res(stl_pkg::KIND_STRING, 1'b0, '0, 1'b1, text_byte_i,
                            stl_pkg::ERR_NONE);
          end
        end
        stl_pkg::MODE_ESCAPE: begin
          main_v = 1'b1;
          if ((text_byte_i == stl_pkg::CH_QUOTE) || (text_byte_i == stl_pkg::CH_BACKSLASH)) begin
            main_r = mk_res(stl_pkg::KIND_STRING, 1'b0, '0, 1'b1, text_byte_i,
                            stl_pkg::ERR_NONE);
          end else if (text_byte_i == stl_pkg::CH_LOWER_N) begin
            main_r = mk_res(stl_pkg::KIND_STRING, 1'b0, '0, 1'b1, stl_pkg::CH_NEWLINE,
                            stl_pkg::ERR_NONE);
          end else begin
            main_r = mk_res(stl_pkg::KIND_SEMI, 1'b0, '0, 1'b0, '0,
                            stl_pkg::ERR_BAD_ESCAPE);
          end
        end
        default: begin
        end
      endcase

      // Result of the byte lexed from the idle mode.
      if (relex && !is_ws) begin
        if (is_punct) begin
          main_v = 1'b1;
          main_r = mk_res(punct_kind, 1'b1, '0, 1'b0, '0, stl_pkg::ERR_NONE);
        end else if (is_let) begin
          main_v = 1'b1;
          main_r = mk_res(stl_pkg::KIND_IDENT, 1'b0, '0, 1'b1, text_byte_i,
                          stl_pkg::ERR_NONE);
        end else if ((text_byte_i != stl_pkg::CH_HASH) && (text_byte_i != stl_pkg::CH_QUOTE)
                     && (text_byte_i != stl_pkg::CH_AT) && (text_byte_i != stl_pkg::CH_COLON)
                     && !is_dig && (text_byte_i != stl_pkg::CH_MINUS)) begin
          main_v = 1'b1;
          main_r = mk_res(stl_pkg::KIND_SEMI, 1'b0, '0, 1'b0, '0, stl_pkg::ERR_BAD_CHAR);
        end
      end
    end
  end

  // Order the results and mark the final one.
  always_comb begin
    res0      = pre_v ? pre_r : main_r;
    res0.last = !(pre_v && main_v);
    res1      = main_r;
    res1.last = 1'b1;
    n_push    = in_acc ? (2'(pre_v) + 2'(main_v)) : 2'd0;
    count_d   = count_q + RES_CNT_W'(n_push) - RES_CNT_W'(out_acc);
  end

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stl_pkg::MODE_IDLE;
      acc_q   <= '0;
      minus_q <= 1'b0;
      digit_q <= 1'b0;
      cnt_q   <= '0;
      err_q   <= stl_pkg::ERR_NONE;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      minus_q <= minus_d;
      digit_q <= digit_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RES_PTR_W'(n_push);
      rd_ptr_q <= rd_ptr_q + RES_PTR_W'(out_acc);
      count_q  <= count_d;
    end
  end

  // Result queue storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      res_mem[wr_ptr_q] <= res0;
    end
    if (n_push == 2'd2) begin
      res_mem[wr_ptr_q + RES_PTR_W'(1)] <= res1;
    end
  end

  // Head of the queue drives the output fields.
  assign token_kind_o      = res_mem[rd_ptr_q].kind;
  assign token_done_o      = res_mem[rd_ptr_q].done;
  assign int_value_o       = res_mem[rd_ptr_q].int_value;
  assign text_char_valid_o = res_mem[rd_ptr_q].char_valid;
  assign text_char_o       = res_mem[rd_ptr_q].text_char;
  assign error_code_o      = res_mem[rd_ptr_q].err;
  assign last_o            = res_mem[rd_ptr_q].last;

  // The queue never holds more results than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= RES_CNT_W'(stl_pkg::RES_DEPTH))
    else $error("result queue overfilled");

  // Once an error is held, text bytes leave the lexer in the error mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !action_i && (mode_q == stl_pkg::MODE_ERROR))
      |=> (mode_q == stl_pkg::MODE_ERROR))
    else $error("error mode left before end of text");

  // End of text returns the lexer to idle with no held error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && action_i) |=> ((mode_q == stl_pkg::MODE_IDLE) && (err_q == stl_pkg::ERR_NONE)))
    else $error("lexer not cleared after end of text");

  // An error result never completes a token, but for the end result, which is always complete.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (error_code_o != stl_pkg::ERR_NONE))
      |-> (token_done_o == (token_kind_o == stl_pkg::KIND_END)))
    else $error("error result with wrong completion flag");

endmodule
